@@ hw/rtl/cei_pkg.sv @@
// Shared types, constants and coefficient tables for the elliptic integral pipeline.
package cei_pkg;

    localparam int PARAM_W = 24;
    localparam int RES_W   = 24;
    localparam int COEF_W  = 32;
    localparam int X_W     = 31;

    localparam int LOG_LAT    = 37;
    localparam int HORNER_LAT = 4;
    localparam int X_DLY      = LOG_LAT - HORNER_LAT;
    localparam int PIPE_LAST  = LOG_LAT + 2;

    localparam logic [63:0] DEC_ONE = 64'd100000000000;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [RES_W-1:0] OUT_MAX = {RES_W{1'b1}};

    typedef logic [4:0][COEF_W-1:0] t_coef;

    function automatic logic [COEF_W-1:0] dec_to_q30(input logic [63:0] d);
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] v;
        t = d << 20;
        q = t / DEC_ONE;
        r = t % DEC_ONE;
        v = (q << 10) + (((r << 10) + (DEC_ONE >> 1)) / DEC_ONE);
        return v[COEF_W-1:0];
    endfunction

    localparam t_coef KA = {dec_to_q30(64'd1451196212), dec_to_q30(64'd3742563713),
        dec_to_q30(64'd3590092383), dec_to_q30(64'd9666344259),
        dec_to_q30(64'd138629436112)};
    localparam t_coef KB = {dec_to_q30(64'd441787012), dec_to_q30(64'd3328355346),
        dec_to_q30(64'd6880248576), dec_to_q30(64'd12498593597),
        dec_to_q30(64'd50000000000)};
    localparam t_coef EA = {dec_to_q30(64'd1736506451), dec_to_q30(64'd4757383546),
        dec_to_q30(64'd6260601220), dec_to_q30(64'd44325141463),
        dec_to_q30(64'd100000000000)};
    localparam t_coef EB = {dec_to_q30(64'd526449639), dec_to_q30(64'd4069697526),
        dec_to_q30(64'd9200180037), dec_to_q30(64'd24998368310),
        dec_to_q30(64'd100000000000)};

endpackage

@@ hw/rtl/cei_if.sv @@
// Valid/ready channel interfaces for parameter beats and result beats.
interface cei_in_if import cei_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PARAM_W-1:0] param_m;
    modport source(output valid, output param_m, input ready);
    modport sink(input valid, input param_m, output ready);
endinterface

interface cei_out_if import cei_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] integral_k;
    logic [RES_W-1:0] integral_e;
    modport source(output valid, output integral_k, output integral_e, input ready);
    modport sink(input valid, input integral_k, input integral_e, output ready);
endinterface

@@ hw/rtl/cei_log.sv @@
// Pipelined ln(2^MFB / v) in Q28 by leading-one search and bitwise squaring.
module cei_log import cei_pkg::*; #(
    parameter int MFB = 24,
    localparam int KW = $clog2(MFB + 1),
    localparam int LGW = KW + 29
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [MFB:0]   i_v,
    output logic [LGW-1:0] o_lg
);

    localparam int DW = KW + 32;

    logic [KW-1:0]      n_k;
    logic [KW-1:0]      r_k;
    logic [MFB:0]       r_v;
    logic [KW:0]        w_sh;
    logic [MFB+32:0]    w_norm;
    logic [31:0]        r_sx [0:32];
    logic [31:0]        r_sf [0:32];
    logic [KW-1:0]      r_sk [0:32];
    logic [DW-1:0]      r_d;
    logic [DW+15:0]     r_ph;
    logic [31:0]        r_pl;
    logic [47:0]        w_pl;
    logic [DW+16:0]     w_sum;
    logic [LGW-1:0]     r_lg;

    always_comb begin
        n_k = '0;
        for (int i = 0; i <= MFB; i++) begin
            if (i_v[i]) begin
                n_k = KW'(i);
            end
        end
    end

    assign w_sh   = {1'b0, r_k} + (KW+1)'(1);
    assign w_norm = {r_v, 32'b0} >> w_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k     <= n_k;
            r_v     <= i_v;
            r_sx[0] <= w_norm[31:0];
            r_sf[0] <= '0;
            r_sk[0] <= r_k;
        end
    end

    for (genvar g = 1; g <= 32; g++) begin : g_sq
        logic [63:0] w_p;
        logic [32:0] w_t;
        logic [31:0] n_x;
        logic [31:0] n_f;
        assign w_p = r_sx[g-1] * r_sx[g-1];
        assign w_t = w_p[63:31];
        always_comb begin
            n_f = r_sf[g-1];
            if (w_t[32]) begin
                n_x = w_t[32:1];
                n_f[32-g] = 1'b1;
            end else begin
                n_x = w_t[31:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sx[g] <= n_x;
                r_sf[g] <= n_f;
                r_sk[g] <= r_sk[g-1];
            end
        end
    end

    assign w_pl  = r_d[15:0] * LN2_Q32;
    assign w_sum = (DW+17)'(r_ph) + (DW+17)'(r_pl) + (DW+17)'(1 << 19);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d  <= {KW'(MFB) - r_sk[32], 32'b0} - DW'(r_sf[32]);
            r_ph <= r_d[DW-1:16] * LN2_Q32;
            r_pl <= w_pl[47:16];
            r_lg <= w_sum[LGW+19:20];
        end
    end

    assign o_lg = r_lg;

endmodule

@@ hw/rtl/cei_horner.sv @@
// Four-stage Horner evaluation of a quartic in Q30.
module cei_horner import cei_pkg::*; #(
    parameter t_coef COEF = KA
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [X_W-1:0]    i_x,
    output logic [COEF_W-1:0] o_acc
);

    logic [COEF_W-1:0] r_acc [1:4];
    logic [X_W-1:0]    r_hx  [1:3];

    for (genvar g = 1; g <= 4; g++) begin : g_step
        logic [COEF_W-1:0]     w_a;
        logic [X_W-1:0]        w_x;
        logic [COEF_W+X_W-1:0] w_p;
        logic [COEF_W+X_W-1:0] w_r;
        if (g == 1) begin : g_first
            assign w_a = COEF[4];
            assign w_x = i_x;
        end else begin : g_next
            assign w_a = r_acc[g-1];
            assign w_x = r_hx[g-1];
        end
        assign w_p = w_a * w_x;
        assign w_r = (w_p + (COEF_W+X_W)'(1 << 29)) >> 30;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[g] <= w_r[COEF_W-1:0] + COEF[4-g];
            end
        end
        if (g < 4) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_hx[g] <= w_x;
                end
            end
        end
    end

    assign o_acc = r_acc[4];

endmodule

@@ hw/rtl/cei_combine.sv @@
// Two-stage a + b * lg with rounding to Q4.20 and saturation.
module cei_combine import cei_pkg::*; #(
    parameter int LGW = 34
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [COEF_W-1:0] i_a,
    input  logic [COEF_W-1:0] i_b,
    input  logic [LGW-1:0]    i_lg,
    output logic [RES_W-1:0]  o_res
);

    localparam int PW = COEF_W + LGW;
    localparam int SW = PW - 26;

    logic [PW-1:0]     r_p;
    logic [COEF_W-1:0] r_a;
    logic [PW:0]       w_pr;
    logic [SW:0]       w_s;
    logic [SW:0]       w_r;
    logic [RES_W-1:0]  r_res;

    assign w_pr = ((PW+1)'(r_p) + (PW+1)'(1 << 27)) >> 28;
    assign w_s  = (SW+1)'(r_a) + (SW+1)'(w_pr) + (SW+1)'(512);
    assign w_r  = w_s >> 10;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= i_b * i_lg;
            r_a   <= i_a;
            r_res <= (w_r > (SW+1)'(OUT_MAX)) ? OUT_MAX : w_r[RES_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

@@ hw/rtl/complete_elliptic_integrals_ke.sv @@
// Complete elliptic integrals K(m) and E(m) in Q4.20 from an unsigned fraction m.
// An input beat passes the input stage, the 37-stage logarithm and the 2-stage combine.
// Throughput: one beat per cycle unless the sink stalls the pipeline.
// The logarithm squaring chain holds one multiplier per stage.
// The whole pipeline holds while a result waits and the sink is not ready.
// Reset clears the valid bits only; data registers are not reset.
module complete_elliptic_integrals_ke import cei_pkg::*; #(
    parameter int M_FRAC_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cei_in_if.sink    i_in,
    cei_out_if.source o_out
);

    localparam int KW  = $clog2(M_FRAC_BITS + 1);
    localparam int LGW = KW + 29;

    logic                    w_en;
    logic [PIPE_LAST:0]      r_vld;
    logic [M_FRAC_BITS-1:0]  w_m;
    logic [M_FRAC_BITS:0]    w_m1;
    logic [M_FRAC_BITS+30:0] w_xw;
    logic [M_FRAC_BITS:0]    r_m1;
    logic [X_W-1:0]          r_xd [0:X_DLY];
    logic [LGW-1:0]          w_lg;
    logic [COEF_W-1:0]       w_ka;
    logic [COEF_W-1:0]       w_kb;
    logic [COEF_W-1:0]       w_ea;
    logic [COEF_W-1:0]       w_eb;

    assign w_en       = !r_vld[PIPE_LAST] || o_out.ready;
    assign i_in.ready = w_en;
    assign w_m        = M_FRAC_BITS'(i_in.param_m);
    assign w_m1       = {1'b1, {M_FRAC_BITS{1'b0}}} - {1'b0, w_m};
    assign w_xw       = {w_m1, 30'b0} >> M_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAST-1:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1    <= w_m1;
            r_xd[0] <= w_xw[X_W-1:0];
            for (int i = 1; i <= X_DLY; i++) begin
                r_xd[i] <= r_xd[i-1];
            end
        end
    end

    cei_log #(.MFB(M_FRAC_BITS)) u_log (
        .i_clk(i_clk), .i_en(w_en), .i_v(r_m1), .o_lg(w_lg)
    );

    cei_horner #(.COEF(KA)) u_ka (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_xd[X_DLY]), .o_acc(w_ka)
    );
    cei_horner #(.COEF(KB)) u_kb (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_xd[X_DLY]), .o_acc(w_kb)
    );
    cei_horner #(.COEF(EA)) u_ea (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_xd[X_DLY]), .o_acc(w_ea)
    );
    cei_horner #(.COEF(EB)) u_eb (
        .i_clk(i_clk), .i_en(w_en), .i_x(r_xd[X_DLY]), .o_acc(w_eb)
    );

    cei_combine #(.LGW(LGW)) u_cmb_k (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_ka), .i_b(w_kb), .i_lg(w_lg),
        .o_res(o_out.integral_k)
    );
    cei_combine #(.LGW(LGW)) u_cmb_e (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_ea), .i_b(w_eb), .i_lg(w_lg),
        .o_res(o_out.integral_e)
    );

    assign o_out.valid = r_vld[PIPE_LAST];

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("valid bits not cleared by reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
    a_beat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> $countones(r_vld) ==
            $past($countones(r_vld[PIPE_LAST-1:0])) + $past(32'(i_in.valid)))
        else $error("beat lost or duplicated in pipeline");

endmodule

@@ test/complete_elliptic_integrals_ke_test.sv @@
// Testbench for the elliptic integral pipeline: stimulus, predictor and result checks.
`timescale 1ns / 100ps

module complete_elliptic_integrals_ke_test;
    import cei_pkg::*;

    typedef logic [63:0] u64;

    typedef struct packed {
        logic [RES_W-1:0] k;
        logic [RES_W-1:0] e;
    } t_integrals;

    typedef struct {
        logic [PARAM_W-1:0] m;
        bit                 typed;
        t_integrals         want;
    } t_row;

    localparam int FRAC   = 24;
    localparam int WD_MAX = 20000;
    localparam int N_RAND = 400;
    localparam logic [RES_W-1:0] HALF_PI_Q20 = 24'd1647099;

    localparam u64 TEN11 = 64'd100000000000;
    localparam u64 LN2   = 64'hB172_17F8;
    localparam u64 K_A[5] = '{64'd138629436112, 64'd9666344259, 64'd3590092383,
        64'd3742563713, 64'd1451196212};
    localparam u64 K_B[5] = '{64'd50000000000, 64'd12498593597, 64'd6880248576,
        64'd3328355346, 64'd441787012};
    localparam u64 E_A[5] = '{64'd100000000000, 64'd44325141463, 64'd6260601220,
        64'd4757383546, 64'd1736506451};
    localparam u64 E_B[5] = '{64'd100000000000, 64'd24998368310, 64'd9200180037,
        64'd4069697526, 64'd526449639};

    logic i_clk;
    logic i_rst_n;

    cei_in_if  param_ch ();
    cei_out_if result_ch ();

    complete_elliptic_integrals_ke i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (param_ch.sink),
        .o_out   (result_ch.source)
    );

    t_integrals pending_integrals[$];
    int         errors;
    int         quiet_cycles;
    int         send_idle_pct;
    int         recv_stall_pct;

    function automatic u64 decimal_to_q30(u64 d);
        u64 t;
        t = d << 20;
        return ((t / TEN11) << 10) + ((((t % TEN11) << 10) + TEN11 / 2) / TEN11);
    endfunction

    function automatic u64 horner_q30(u64 c[5], u64 x);
        u64 acc;
        acc = decimal_to_q30(c[4]);
        for (int j = 3; j >= 0; j--)
            acc = ((acc * x + (64'd1 << 29)) >> 30) + decimal_to_q30(c[j]);
        return acc;
    endfunction

    function automatic u64 log_inverse_q28(u64 v);
        int unsigned msb;
        u64 x;
        u64 frac;
        u64 d;
        msb = 32;
        frac = 0;
        while (msb > 0 && v[msb] == 1'b0)
            msb--;
        x = (msb <= 31) ? (v << (31 - msb)) : (v >> (msb - 31));
        for (int i = 1; i <= 32; i++) begin
            x = (x * x) >> 31;
            if (x >= (64'd1 << 32)) begin
                x = x >> 1;
                frac = frac | (64'd1 << (32 - i));
            end
        end
        d = (u64'(FRAC) << 32) - ((u64'(msb) << 32) + frac);
        return ((d >> 16) * LN2 + (((d & 64'hFFFF) * LN2) >> 16) + (64'd1 << 19)) >> 20;
    endfunction

    function automatic logic [RES_W-1:0] poly_log_q20(u64 ca[5], u64 cb[5], u64 x, u64 lg);
        u64 s;
        u64 r;
        s = horner_q30(ca, x) + ((horner_q30(cb, x) * lg + (64'd1 << 27)) >> 28);
        r = (s + 64'd512) >> 10;
        return (r > 64'hFFFFFF) ? OUT_MAX : r[RES_W-1:0];
    endfunction

    function automatic t_integrals predict_integrals(logic [PARAM_W-1:0] m);
        u64 m1;
        u64 x;
        u64 lg;
        t_integrals res;
        m1 = (64'd1 << FRAC) - (u64'(m) & ((64'd1 << FRAC) - 1));
        x  = (m1 << 30) >> FRAC;
        lg = log_inverse_q28(m1);
        res.k = poly_log_q20(K_A, K_B, x, lg);
        res.e = poly_log_q20(E_A, E_B, x, lg);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [RES_W-1:0] got, logic [RES_W-1:0] want);
        $display("mismatch %s: got %06h want %06h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [PARAM_W-1:0] random_m();
        case ($urandom_range(3))
            0: return PARAM_W'($urandom);
            1: return 24'hFFFFFF - PARAM_W'($urandom_range(255));
            2: return PARAM_W'($urandom_range(255));
            default: return PARAM_W'($urandom) >> $urandom_range(23);
        endcase
    endfunction

    task automatic send_param(logic [PARAM_W-1:0] m, bit typed, t_integrals want);
        while ($urandom_range(99) < send_idle_pct) begin
            param_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        param_ch.valid   <= 1'b1;
        param_ch.param_m <= m;
        do @(posedge i_clk); while (!param_ch.ready);
        pending_integrals.push_back(typed ? want : predict_integrals(m));
    endtask

    task automatic drain_results();
        param_ch.valid <= 1'b0;
        while (pending_integrals.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (param_ch.valid && param_ch.ready || result_ch.valid && result_ch.ready)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_integrals.size() == 0) begin
                report_mismatch("unexpected beat k", result_ch.integral_k, '0);
            end else begin
                t_integrals want;
                want = pending_integrals.pop_front();
                if (result_ch.integral_k !== want.k)
                    report_mismatch("integral_k", result_ch.integral_k, want.k);
                if (result_ch.integral_e !== want.e)
                    report_mismatch("integral_e", result_ch.integral_e, want.e);
            end
        end
    end

    t_row directed[13] = '{
        '{24'h000000, 1'b1, '{HALF_PI_Q20, HALF_PI_Q20}},
        '{24'h000001, 1'b0, '{'0, '0}},
        '{24'h000002, 1'b0, '{'0, '0}},
        '{24'h400000, 1'b0, '{'0, '0}},
        '{24'h800000, 1'b0, '{'0, '0}},
        '{24'hC00000, 1'b0, '{'0, '0}},
        '{24'h555555, 1'b0, '{'0, '0}},
        '{24'hAAAAAA, 1'b0, '{'0, '0}},
        '{24'hF0F0F0, 1'b0, '{'0, '0}},
        '{24'hFFFF00, 1'b0, '{'0, '0}},
        '{24'hFFFFFD, 1'b0, '{'0, '0}},
        '{24'hFFFFFE, 1'b0, '{'0, '0}},
        '{24'hFFFFFF, 1'b0, '{'0, '0}}
    };

    initial begin
        int idle_plan[4][2];
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_plan = '{'{0, 0}, '{64, 0}, '{0, 64}, '{17, 17}};
        i_rst_n = 1'b0;
        param_ch.valid = 1'b0;
        param_ch.param_m = '0;
        result_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            send_param(directed[i].m, directed[i].typed, directed[i].want);
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            if (p == 2)
                drain_results();
            for (int n = 0; n < N_RAND; n++)
                send_param(random_m(), 1'b0, '{'0, '0});
        end
        drain_results();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
